[rtl/vmm_pkg.sv]
// ----------------------------------------------------------------------------
// vmm_pkg: shared types and helpers of the min/max block pyramid
// Cell and result records, memory depths, block-done test and the
// accumulator address map for levels 1 to 4.
// ----------------------------------------------------------------------------
package vmm_pkg;

    localparam int LEVELS      = 5;
    localparam int SIDE        = 257;
    localparam int PLANE_DEPTH = SIDE * SIDE;
    localparam int ROW_DEPTH   = SIDE;
    localparam int ACC_DEPTH   = 21760;
    localparam int ITEM_DEPTH  = 4;
    localparam int OUT_DEPTH   = 8;
    localparam int MAX_RESULTS = LEVELS;

    localparam int PA_W   = $clog2(PLANE_DEPTH);
    localparam int ACC_AW = $clog2(ACC_DEPTH);

    // one completed unit cell, handed to the accumulator walker
    typedef struct packed {
        logic [7:0] cx;
        logic [7:0] cy;
        logic [7:0] cz;
        logic [8:0] w;
        logic [8:0] d;
        logic [8:0] h;
        logic [7:0] lo;
        logic [7:0] hi;
    } t_cell;

    // one result record
    typedef struct packed {
        logic [2:0] level;
        logic [7:0] bx;
        logic [7:0] by;
        logic [7:0] bz;
        logic [7:0] bmin;
        logic [7:0] bmax;
        logic       last;
    } t_result;

    // push port of the result queue
    typedef struct packed {
        logic    push;
        t_result data;
    } t_res_push;

    // out-of-range sizes clamp to 2 .. SIDE
    function automatic logic [8:0] f_eff(input logic [8:0] v);
        logic [8:0] r;
        r = v;
        if (v < 9'd2) begin
            r = 9'd2;
        end else if (v > 9'(SIDE)) begin
            r = 9'(SIDE);
        end
        return r;
    endfunction

    // a child closes its parent on one axis when odd or at the edge
    function automatic logic f_axis_done(input logic [7:0] c, input logic [8:0] n);
        return c[0] || (({1'b0, c} + 9'd1) >= n);
    endfunction

    function automatic logic f_done(input t_cell c);
        return f_axis_done(c.cx, c.w) && f_axis_done(c.cy, c.d) &&
               f_axis_done(c.cz, c.h);
    endfunction

    // accumulator slot of block (px, py) at level 1..4, regions packed back to back
    function automatic logic [ACC_AW-1:0] f_acc_addr(input logic [2:0] lvl,
                                                     input logic [7:0] px,
                                                     input logic [7:0] py);
        logic [ACC_AW-1:0] a;
        case (lvl)
            3'd1:    a = {1'b0, py[6:0], px[6:0]};
            3'd2:    a = {3'b100, py[5:0], px[5:0]};
            3'd3:    a = {5'b10100, py[4:0], px[4:0]};
            3'd4:    a = {7'b1010100, py[3:0], px[3:0]};
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

[rtl/volume_minmax_block_pyramid_top.sv]
// ----------------------------------------------------------------------------
// volume_minmax_block_pyramid_top: streaming 3D min/max block pyramid
// Voxels in raster order (x fastest) in, min/max blocks of levels 0..4 out.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carries one voxel per transaction.
// Output channel: o_valid / i_stall carries one block result per transaction;
// o_last marks the final result caused by a voxel. A voxel on the first
// row, slice or column of the volume gives no result.
// Config: i_cfg_valid / o_cfg_ready (always ready) writes volume_x (0),
// volume_y (1) or volume_z (2); a write restarts the volume. Write only
// while the block is idle.
// Throughput: a voxel that completes a unit cell occupies the accumulator
// walker for a start step and one read-merge-write per pyramid level it
// updates (1..4); the walker takes no new cell until done. Edge voxels are
// taken every cycle while o_stall is low. The walker shares one accumulator
// memory port pair across levels. A level 0 result passes stage B, the cell
// queue and the result queue before o_valid rises.
// Reset: position counters go to the start of a volume, sizes to 257,
// queues empty. A stalled receiver fills the 8-entry result queue, then
// the 4-entry cell queue, then o_stall rises.
// ----------------------------------------------------------------------------
module volume_minmax_block_pyramid_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_voxel,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_level,
    output logic [7:0] o_block_x,
    output logic [7:0] o_block_y,
    output logic [7:0] o_block_z,
    output logic [7:0] o_block_min,
    output logic [7:0] o_block_max,
    output logic       o_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [8:0] i_cfg_data
);

    logic               cell_valid, cell_pop;
    vmm_pkg::t_cell     cell_rec;
    vmm_pkg::t_res_push res;
    vmm_pkg::t_result   out_data;
    logic [3:0]         out_cnt;

    assign o_cfg_ready = 1'b1;

    vmm_line_buf u_line_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_voxel      (i_voxel),
        .o_stall      (o_stall),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_cell_valid (cell_valid),
        .o_cell       (cell_rec),
        .i_cell_pop   (cell_pop)
    );

    vmm_acc_walk u_acc_walk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cell_valid (cell_valid),
        .i_cell       (cell_rec),
        .o_cell_pop   (cell_pop),
        .i_out_cnt    (out_cnt),
        .o_res        (res)
    );

    vmm_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .o_cnt   (out_cnt),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (out_data)
    );

    assign o_level     = out_data.level;
    assign o_block_x   = out_data.bx;
    assign o_block_y   = out_data.by;
    assign o_block_z   = out_data.bz;
    assign o_block_min = out_data.bmin;
    assign o_block_max = out_data.bmax;
    assign o_last      = out_data.last;

endmodule

[rtl/vmm_line_buf.sv]
// ----------------------------------------------------------------------------
// vmm_line_buf: voxel position tracking, slice/row buffers and unit cells
// A plane memory keeps the previous slice, a row memory keeps the previous
// row (current and previous slice); the 8 corners give the level 0 min/max.
// ----------------------------------------------------------------------------
module vmm_line_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_voxel,
    output logic                o_stall,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [8:0]          i_cfg_data,
    output logic                o_cell_valid,
    output vmm_pkg::t_cell      o_cell,
    input  logic                i_cell_pop
);

    localparam logic [1:0] REG_VOL_X = 2'd0;
    localparam logic [1:0] REG_VOL_Y = 2'd1;
    localparam logic [1:0] REG_VOL_Z = 2'd2;
    localparam int IQ_AW = $clog2(vmm_pkg::ITEM_DEPTH);

    logic [8:0] r_vol_x, r_vol_y, r_vol_z;
    logic [8:0] r_pos_x, r_pos_y, r_pos_z;
    logic [8:0] n_pos_x, n_pos_y, n_pos_z;
    logic [vmm_pkg::PA_W-1:0] r_pa, n_pa;
    logic [8:0] ex, ey, ez;
    logic       accept;

    logic [7:0]  plane_mem [vmm_pkg::PLANE_DEPTH];
    logic [15:0] row_mem [vmm_pkg::ROW_DEPTH];
    logic [7:0]  r_pl_rd;
    logic [15:0] r_row_rd;

    logic                     r_b_valid;
    logic [7:0]               r_b_vox;
    logic [8:0]               r_b_x, r_b_y, r_b_z;
    logic [vmm_pkg::PA_W-1:0] r_b_pa;
    logic [7:0]               r_prev_vox, r_prev_pl;
    logic [15:0]              r_prev_row;

    logic          cell_ok;
    vmm_pkg::t_cell cell_rec;
    logic [7:0]    corner [8];
    logic [7:0]    lo, hi;

    vmm_pkg::t_cell   iq [vmm_pkg::ITEM_DEPTH];
    logic [IQ_AW-1:0] r_iq_wp, r_iq_rp;
    logic [IQ_AW:0]   r_iq_cnt;
    logic             iq_push;

    assign ex = vmm_pkg::f_eff(r_vol_x);
    assign ey = vmm_pkg::f_eff(r_vol_y);
    assign ez = vmm_pkg::f_eff(r_vol_z);

    // hold off while the stage B item might not find room in the queue
    assign o_stall = (r_iq_cnt + {{IQ_AW{1'b0}}, r_b_valid}) >= (IQ_AW+1)'(vmm_pkg::ITEM_DEPTH);
    assign accept  = i_valid && !o_stall;

    // raster position and linear plane address of the next voxel
    always_comb begin
        n_pos_x = r_pos_x + 9'd1;
        n_pos_y = r_pos_y;
        n_pos_z = r_pos_z;
        n_pa    = r_pa + 1'b1;
        if (n_pos_x >= ex) begin
            n_pos_x = '0;
            n_pos_y = r_pos_y + 9'd1;
            if (n_pos_y >= ey) begin
                n_pos_y = '0;
                n_pa    = '0;
                n_pos_z = r_pos_z + 9'd1;
                if (n_pos_z >= ez) begin
                    n_pos_z = '0;
                end
            end
        end
    end

    // config registers and position counters; a write to volume_x, volume_y or volume_z restarts the volume
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol_x <= 9'd257;
            r_vol_y <= 9'd257;
            r_vol_z <= 9'd257;
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_pos_z <= '0;
            r_pa    <= '0;
        end else if (i_cfg_we && i_cfg_index <= REG_VOL_Z) begin
            case (i_cfg_index)
                REG_VOL_X: r_vol_x <= i_cfg_data;
                REG_VOL_Y: r_vol_y <= i_cfg_data;
                REG_VOL_Z: r_vol_z <= i_cfg_data;
                default:   r_vol_x <= r_vol_x;
            endcase
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_pos_z <= '0;
            r_pa    <= '0;
        end else if (accept) begin
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
            r_pos_z <= n_pos_z;
            r_pa    <= n_pa;
        end
    end

    // buffer reads at accept, write-back in stage B
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pl_rd  <= plane_mem[r_pa];
            r_row_rd <= row_mem[r_pos_x];
        end
        if (r_b_valid) begin
            plane_mem[r_b_pa] <= r_b_vox;
            row_mem[r_b_x]    <= {r_b_vox, r_pl_rd};
        end
    end

    // stage B payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= accept;
        end
        if (accept) begin
            r_b_vox <= i_voxel;
            r_b_x   <= r_pos_x;
            r_b_y   <= r_pos_y;
            r_b_z   <= r_pos_z;
            r_b_pa  <= r_pa;
        end
        if (r_b_valid) begin
            r_prev_vox <= r_b_vox;
            r_prev_pl  <= r_pl_rd;
            r_prev_row <= r_row_rd;
        end
    end

    // unit cell min/max over the 8 corners
    always_comb begin
        corner[0] = r_b_vox;
        corner[1] = r_prev_vox;
        corner[2] = r_row_rd[15:8];
        corner[3] = r_prev_row[15:8];
        corner[4] = r_pl_rd;
        corner[5] = r_prev_pl;
        corner[6] = r_row_rd[7:0];
        corner[7] = r_prev_row[7:0];
        lo = corner[0];
        hi = corner[0];
        for (int i = 1; i < 8; i++) begin
            if (corner[i] < lo) lo = corner[i];
            if (corner[i] > hi) hi = corner[i];
        end
        cell_rec.cx = 8'(r_b_x - 9'd1);
        cell_rec.cy = 8'(r_b_y - 9'd1);
        cell_rec.cz = 8'(r_b_z - 9'd1);
        cell_rec.w  = ex - 9'd1;
        cell_rec.d  = ey - 9'd1;
        cell_rec.h  = ez - 9'd1;
        cell_rec.lo = lo;
        cell_rec.hi = hi;
        cell_ok = (r_b_x != '0) && (r_b_y != '0) && (r_b_z != '0);
    end

    assign iq_push = r_b_valid && cell_ok;

    // small cell queue toward the walker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iq_wp  <= '0;
            r_iq_rp  <= '0;
            r_iq_cnt <= '0;
        end else begin
            if (iq_push) r_iq_wp <= r_iq_wp + 1'b1;
            if (i_cell_pop) r_iq_rp <= r_iq_rp + 1'b1;
            r_iq_cnt <= r_iq_cnt + {{IQ_AW{1'b0}}, iq_push} - {{IQ_AW{1'b0}}, i_cell_pop};
        end
        if (iq_push) iq[r_iq_wp] <= cell_rec;
    end

    assign o_cell_valid = (r_iq_cnt != '0);
    assign o_cell       = iq[r_iq_rp];

`ifndef SYNTHESIS
    a_iq_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        iq_push |-> (r_iq_cnt < (IQ_AW+1)'(vmm_pkg::ITEM_DEPTH) || i_cell_pop))
        else $error("cell queue overflow");
`endif

endmodule

[rtl/vmm_acc_walk.sv]
// ----------------------------------------------------------------------------
// vmm_acc_walk: accumulator memory and level walker
// Per cell: emit level 0, then read-merge-write the parent slot level by
// level while the child closes its parent, emitting each closed block.
// ----------------------------------------------------------------------------
module vmm_acc_walk (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cell_valid,
    input  vmm_pkg::t_cell      i_cell,
    output logic                o_cell_pop,
    input  logic [3:0]          i_out_cnt,
    output vmm_pkg::t_res_push  o_res
);

    logic [15:0] acc_mem [vmm_pkg::ACC_DEPTH];
    logic [15:0] r_acc_rd;
    logic        rd_en, wr_en;
    logic [vmm_pkg::ACC_AW-1:0] rd_addr, wr_addr;
    logic [15:0] wr_data;

    logic           r_busy, n_busy;
    logic [2:0]     r_lvl, n_lvl;
    vmm_pkg::t_cell r_c, n_c;
    vmm_pkg::t_cell up;
    logic           first, fin;
    logic [7:0]     m_lo, m_hi;

    // accumulator memory, one read and one write port
    always_ff @(posedge i_clk) begin
        if (rd_en) r_acc_rd <= acc_mem[rd_addr];
        if (wr_en) acc_mem[wr_addr] <= wr_data;
    end

    always_comb begin
        o_cell_pop = 1'b0;
        o_res      = '0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        rd_addr    = '0;
        wr_addr    = '0;
        wr_data    = '0;
        n_busy     = r_busy;
        n_lvl      = r_lvl;
        n_c        = r_c;

        // merge of this level with the stored partial block
        first = ~(r_c.cx[0] | r_c.cy[0] | r_c.cz[0]);
        m_lo  = (!first && r_acc_rd[15:8] < r_c.lo) ? r_acc_rd[15:8] : r_c.lo;
        m_hi  = (!first && r_acc_rd[7:0] > r_c.hi) ? r_acc_rd[7:0] : r_c.hi;
        fin   = vmm_pkg::f_done(r_c);
        up.cx = r_c.cx >> 1;
        up.cy = r_c.cy >> 1;
        up.cz = r_c.cz >> 1;
        up.w  = (r_c.w + 9'd1) >> 1;
        up.d  = (r_c.d + 9'd1) >> 1;
        up.h  = (r_c.h + 9'd1) >> 1;
        up.lo = m_lo;
        up.hi = m_hi;

        if (!r_busy) begin
            // start a cell only with room for all its results
            if (i_cell_valid && i_out_cnt <= 4'(vmm_pkg::OUT_DEPTH - vmm_pkg::MAX_RESULTS)) begin
                o_cell_pop       = 1'b1;
                o_res.push       = 1'b1;
                o_res.data.level = 3'd0;
                o_res.data.bx    = i_cell.cx;
                o_res.data.by    = i_cell.cy;
                o_res.data.bz    = i_cell.cz;
                o_res.data.bmin  = i_cell.lo;
                o_res.data.bmax  = i_cell.hi;
                o_res.data.last  = !vmm_pkg::f_done(i_cell);
                rd_en   = 1'b1;
                rd_addr = vmm_pkg::f_acc_addr(3'd1, i_cell.cx >> 1, i_cell.cy >> 1);
                n_busy  = 1'b1;
                n_lvl   = 3'd1;
                n_c     = i_cell;
            end
        end else begin
            wr_en   = 1'b1;
            wr_addr = vmm_pkg::f_acc_addr(r_lvl, up.cx, up.cy);
            wr_data = {m_lo, m_hi};
            if (fin) begin
                o_res.push       = 1'b1;
                o_res.data.level = r_lvl;
                o_res.data.bx    = up.cx;
                o_res.data.by    = up.cy;
                o_res.data.bz    = up.cz;
                o_res.data.bmin  = m_lo;
                o_res.data.bmax  = m_hi;
                o_res.data.last  = (r_lvl == 3'(vmm_pkg::LEVELS - 1)) || !vmm_pkg::f_done(up);
            end
            if (fin && r_lvl < 3'(vmm_pkg::LEVELS - 1)) begin
                rd_en   = 1'b1;
                rd_addr = vmm_pkg::f_acc_addr(r_lvl + 3'd1, up.cx >> 1, up.cy >> 1);
                n_lvl   = r_lvl + 3'd1;
                n_c     = up;
            end else begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_lvl  <= 3'd1;
        end else begin
            r_busy <= n_busy;
            r_lvl  <= n_lvl;
        end
        r_c <= n_c;
    end

`ifndef SYNTHESIS
    a_walk_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_lvl >= 3'd1 && r_lvl <= 3'(vmm_pkg::LEVELS - 1)))
        else $error("walker level out of range");
    a_walk_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cell_pop |-> !r_busy)
        else $error("cell popped while walking");
`endif

endmodule

[rtl/vmm_out_queue.sv]
// ----------------------------------------------------------------------------
// vmm_out_queue: result queue
// Absorbs result bursts of up to five per voxel; drains one per cycle while i_stall is low.
// ----------------------------------------------------------------------------
module vmm_out_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vmm_pkg::t_res_push  i_res,
    output logic [3:0]          o_cnt,
    output logic                o_valid,
    input  logic                i_stall,
    output vmm_pkg::t_result    o_data
);

    localparam int OQ_AW = $clog2(vmm_pkg::OUT_DEPTH);

    vmm_pkg::t_result oq [vmm_pkg::OUT_DEPTH];
    logic [OQ_AW-1:0] r_wp, r_rp;
    logic [OQ_AW:0]   r_cnt;
    logic             pop;

    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && !i_stall;
    assign o_data  = oq[r_rp];
    assign o_cnt   = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_res.push) r_wp <= r_wp + 1'b1;
            if (pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + {{OQ_AW{1'b0}}, i_res.push} - {{OQ_AW{1'b0}}, pop};
        end
        if (i_res.push) oq[r_wp] <= i_res.data;
    end

`ifndef SYNTHESIS
    a_oq_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res.push |-> (r_cnt < (OQ_AW+1)'(vmm_pkg::OUT_DEPTH) || pop))
        else $error("result queue overflow");
`endif

endmodule

[tb/vmm_tb_pkg.sv]
// ----------------------------------------------------------------------------
// vmm_tb_pkg: register indexes shared by the pyramid testbench files
// Sizes of the volume are written through the config port by index.
// ----------------------------------------------------------------------------
package vmm_tb_pkg;

    typedef enum logic [1:0] {
        REG_VOLUME_X = 2'd0,
        REG_VOLUME_Y = 2'd1,
        REG_VOLUME_Z = 2'd2
    } t_reg_index;

endpackage

[tb/vmm_checker.sv]
// ----------------------------------------------------------------------------
// vmm_checker: scoreboard for the min/max block pyramid
// Watches the voxel, config and result channels, runs its own pyramid
// predictor on every accepted voxel and compares each result transaction
// field by field with the oldest predicted block.
// ----------------------------------------------------------------------------
module vmm_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_stall_in,
    input  logic [7:0] i_voxel,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [2:0] i_level,
    input  logic [7:0] i_block_x,
    input  logic [7:0] i_block_y,
    input  logic [7:0] i_block_z,
    input  logic [7:0] i_block_min,
    input  logic [7:0] i_block_max,
    input  logic       i_last,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [8:0] i_cfg_data,
    output int         o_errors,
    output int         o_pending,
    output int         o_blocks_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HIST_LEN = vmm_pkg::SIDE * vmm_pkg::SIDE + vmm_pkg::SIDE + 1;
    localparam int SLOT_SIDE = vmm_pkg::SIDE / 2;
    localparam int SLOTS = SLOT_SIDE * SLOT_SIDE;

    // predictor state
    logic [7:0]  voxel_line [HIST_LEN];
    int unsigned line_wr;
    logic [7:0]  part_min [vmm_pkg::LEVELS][SLOTS];
    logic [7:0]  part_max [vmm_pkg::LEVELS][SLOTS];
    logic [8:0]  size_x, size_y, size_z;
    int unsigned at_x, at_y, at_z;

    vmm_pkg::t_result expected_blocks [$];

    function automatic int unsigned clamp_size(input logic [8:0] v);
        if (v < 9'd2) return 2;
        if (v > 9'(vmm_pkg::SIDE)) return vmm_pkg::SIDE;
        return {23'd0, v};
    endfunction

    function automatic logic [7:0] line_back(input int unsigned off);
        return voxel_line[(line_wr + HIST_LEN - off) % HIST_LEN];
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
        o_errors++;
    endtask

    // predict the blocks that one voxel closes
    task automatic predict_blocks(input logic [7:0] v);
        int unsigned nx, ny, nz, plane, cx, cy, cz, w, d, h, px, py, pz, slot;
        int unsigned offs [7];
        logic [7:0] lo, hi, c;
        vmm_pkg::t_result r;
        bit done;
        nx = clamp_size(size_x);
        ny = clamp_size(size_y);
        nz = clamp_size(size_z);
        plane = nx * ny;
        if (at_x != 0 && at_y != 0 && at_z != 0) begin
            lo = v;
            hi = v;
            cx = at_x - 1;
            cy = at_y - 1;
            cz = at_z - 1;
            w = nx - 1;
            d = ny - 1;
            h = nz - 1;
            offs = '{1, nx, nx + 1, plane, plane + 1, plane + nx, plane + nx + 1};
            foreach (offs[i]) begin
                c = line_back(offs[i]);
                if (c < lo) lo = c;
                if (c > hi) hi = c;
            end
            r = '{level: 3'd0, bx: cx[7:0], by: cy[7:0], bz: cz[7:0],
                  bmin: lo, bmax: hi, last: 1'b0};
            expected_blocks.push_back(r);
            for (int l = 1; l < vmm_pkg::LEVELS; l++) begin
                px = cx >> 1;
                py = cy >> 1;
                pz = cz >> 1;
                slot = (py * SLOT_SIDE + px) % SLOTS;
                // first child opens the block, the others merge into it
                if (((cx | cy | cz) & 1) != 0) begin
                    if (part_min[l][slot] < lo) lo = part_min[l][slot];
                    if (part_max[l][slot] > hi) hi = part_max[l][slot];
                end
                part_min[l][slot] = lo;
                part_max[l][slot] = hi;
                done = ((cx & 1) != 0 || cx + 1 >= w) &&
                       ((cy & 1) != 0 || cy + 1 >= d) &&
                       ((cz & 1) != 0 || cz + 1 >= h);
                if (!done) break;
                r = '{level: 3'(l), bx: px[7:0], by: py[7:0], bz: pz[7:0],
                      bmin: lo, bmax: hi, last: 1'b0};
                expected_blocks.push_back(r);
                cx = px;
                cy = py;
                cz = pz;
                w = (w + 1) >> 1;
                d = (d + 1) >> 1;
                h = (h + 1) >> 1;
            end
            expected_blocks[$].last = 1'b1;
        end
        voxel_line[line_wr] = v;
        line_wr = (line_wr + 1) % HIST_LEN;
        // advance raster position, wrapping into a new volume
        at_x++;
        if (at_x >= nx) begin
            at_x = 0;
            at_y++;
            if (at_y >= ny) begin
                at_y = 0;
                at_z++;
                if (at_z >= nz) at_z = 0;
            end
        end
    endtask

    initial begin
        o_errors = 0;
        o_blocks_seen = 0;
        foreach (voxel_line[i]) voxel_line[i] = '0;
        foreach (part_min[l, s]) begin
            part_min[l][s] = '0;
            part_max[l][s] = '0;
        end
        line_wr = 0;
        size_x = 9'd257;
        size_y = 9'd257;
        size_z = 9'd257;
        at_x = 0;
        at_y = 0;
        at_z = 0;
    end

    assign o_pending = expected_blocks.size();

    // channel monitor
    always @(posedge i_clk) begin
        vmm_pkg::t_result want;
        if (i_rst_n) begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (vmm_tb_pkg::t_reg_index'(i_cfg_index))
                    vmm_tb_pkg::REG_VOLUME_X: size_x = i_cfg_data;
                    vmm_tb_pkg::REG_VOLUME_Y: size_y = i_cfg_data;
                    vmm_tb_pkg::REG_VOLUME_Z: size_z = i_cfg_data;
                    default: ;
                endcase
                if (i_cfg_index <= vmm_tb_pkg::REG_VOLUME_Z) begin
                    at_x = 0;
                    at_y = 0;
                    at_z = 0;
                end
            end
            if (i_valid && !i_stall_in) predict_blocks(i_voxel);
            if (i_out_valid && !i_out_stall) begin
                o_blocks_seen++;
                if (expected_blocks.size() == 0) begin
                    report_mismatch("result count", o_blocks_seen, o_blocks_seen - 1);
                end else begin
                    want = expected_blocks.pop_front();
                    if (i_level !== want.level) report_mismatch("level", i_level, want.level);
                    if (i_block_x !== want.bx) report_mismatch("block_x", i_block_x, want.bx);
                    if (i_block_y !== want.by) report_mismatch("block_y", i_block_y, want.by);
                    if (i_block_z !== want.bz) report_mismatch("block_z", i_block_z, want.bz);
                    if (i_block_min !== want.bmin)
                        report_mismatch("block_min", i_block_min, want.bmin);
                    if (i_block_max !== want.bmax)
                        report_mismatch("block_max", i_block_max, want.bmax);
                    if (i_last !== want.last) report_mismatch("last", i_last, want.last);
                end
            end
        end
    end

endmodule

[tb/volume_minmax_block_pyramid_top_tb.sv]
// ----------------------------------------------------------------------------
// volume_minmax_block_pyramid_top_tb: stimulus and verdict for the pyramid
// Streams volumes of several sizes (smallest, largest, clamped and odd)
// with directed and random voxels under random sender gaps and receiver
// stalls; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module volume_minmax_block_pyramid_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SHAPES = 9;
    localparam int SETTLE_CYCLES = 24;
    localparam int VOXEL_CAP = 32;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_voxel;
    logic       o_valid;
    logic       i_stall;
    logic [2:0] o_level;
    logic [7:0] o_block_x, o_block_y, o_block_z, o_block_min, o_block_max;
    logic       o_last;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [8:0] i_cfg_data;

    int errors, pending, blocks_seen;
    int send_gap_pct, recv_stall_pct;
    int voxels_sent;

    // raw sizes per phase: x, y, z (values outside 2..257 get clamped)
    logic [8:0] shapes [NUM_SHAPES][3] = '{
        '{9'd2, 9'd2, 9'd2}, '{9'd3, 9'd4, 9'd5}, '{9'd1, 9'd0, 9'd2},
        '{9'd4, 9'd2, 9'd4}, '{9'd511, 9'd2, 9'd2}, '{9'd2, 9'd3, 9'd4},
        '{9'd3, 9'd3, 9'd3}, '{9'd2, 9'd2, 9'd3}, '{9'd5, 9'd2, 9'd3}
    };

    volume_minmax_block_pyramid_top dut (.*);

    vmm_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_stall_in(o_stall), .i_voxel(i_voxel),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_level(o_level), .i_block_x(o_block_x), .i_block_y(o_block_y),
        .i_block_z(o_block_z), .i_block_min(o_block_min), .i_block_max(o_block_max),
        .i_last(o_last),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending), .o_blocks_seen(blocks_seen)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // receiver stalls
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    task automatic write_size(input vmm_tb_pkg::t_reg_index idx, input logic [8:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // one voxel transaction, with an optional idle gap before it
    task automatic send_voxel(input logic [7:0] v);
        if ($urandom_range(0, 99) < send_gap_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_voxel <= v;
        do @(posedge i_clk); while (o_stall);
        voxels_sent++;
    endtask

    task automatic wait_drained();
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // stimulus
    initial begin
        int nx, ny, nz, count, style;
        logic [7:0] base;
        logic [7:0] corner_vals [8];
        corner_vals = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd128, 8'd127, 8'd0, 8'd255};
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_voxel = '0;
        i_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = vmm_tb_pkg::REG_VOLUME_X;
        i_cfg_data = '0;
        send_gap_pct = 24;
        recv_stall_pct = 45;
        voxels_sent = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < NUM_SHAPES; p++) begin
            // idle profile: receiver-heavy, then sender-heavy, then none
            if (p < NUM_SHAPES / 3) begin
                send_gap_pct = 24;
                recv_stall_pct = 45;
            end else if (p < 2 * NUM_SHAPES / 3) begin
                send_gap_pct = 45;
                recv_stall_pct = 24;
            end else begin
                send_gap_pct = 0;
                recv_stall_pct = 0;
            end
            write_size(vmm_tb_pkg::REG_VOLUME_X, shapes[p][0]);
            write_size(vmm_tb_pkg::REG_VOLUME_Y, shapes[p][1]);
            write_size(vmm_tb_pkg::REG_VOLUME_Z, shapes[p][2]);
            nx = shapes[p][0] < 2 ? 2 : (shapes[p][0] > 257 ? 257 : shapes[p][0]);
            ny = shapes[p][1] < 2 ? 2 : (shapes[p][1] > 257 ? 257 : shapes[p][1]);
            nz = shapes[p][2] < 2 ? 2 : (shapes[p][2] > 257 ? 257 : shapes[p][2]);
            // small volumes run whole plus a part of the next to cover wrap
            count = nx * ny * nz + $urandom_range(1, nx * ny);
            if (count > VOXEL_CAP) count = VOXEL_CAP;
            base = 8'($urandom);
            for (int k = 0; k < count; k++) begin
                if (p == 0 && k < 16) begin
                    send_voxel(corner_vals[k % 8] ^ {8{k >= 8}});
                end else begin
                    style = $urandom_range(0, 9);
                    if (style < 5) send_voxel(8'($urandom));
                    else if (style < 7) send_voxel($urandom_range(0, 1) ? 8'd255 : 8'd0);
                    else send_voxel(base + 8'($urandom_range(0, 3)));
                end
            end
            @(negedge i_clk);
            i_valid <= 1'b0;
            wait_drained();
        end

        $display("Streamed %0d voxels over %0d volume shapes, %0d block results checked.",
                 voxels_sent, NUM_SHAPES, blocks_seen);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // watchdog
    initial begin
        #1ms;
        $display("Timeout with %0d results still expected", pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
